// ===== rtl/sip_pkg.sv =====
// ----------------------------------------------------------------------------
// sip_pkg
// Shared types and constants of the sorted ID pool: transaction payloads,
// operation and status codes, register indexes.
// ----------------------------------------------------------------------------
package sip_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int ID_W            = 32;
  localparam int ENTRY_W         = 7;
  localparam int CFG_ADDR_W      = 4;
  localparam int CFG_DATA_W      = 32;

  localparam logic [ID_W-1:0] ID_MAX = '1;

  typedef enum logic [2:0] {
    KIND_INSERT    = 3'd0,
    KIND_LOOKUP    = 3'd1,
    KIND_REMOVE    = 3'd2,
    KIND_FIND_FREE = 3'd3,
    KIND_CLEAR     = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_PARAM = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_TRANS_MIN = 2'd0,
    REG_TRANS_MAX = 2'd1,
    REG_PERS_MIN  = 2'd2,
    REG_PERS_MAX  = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_READ,
    FSM_EVAL,
    FSM_DONE
  } fsm_t;

  typedef struct packed {
    logic [2:0]      kind;
    logic [ID_W-1:0] item_id;
    logic            persistent;
  } sip_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [ID_W-1:0]    result_id;
    logic [ENTRY_W-1:0] entry_count;
  } sip_out_t;

endpackage

// ===== rtl/sip_ram.sv =====
// ----------------------------------------------------------------------------
// sip_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sorted_id_pool_top.sv =====
// ----------------------------------------------------------------------------
// sorted_id_pool_top
// Sorted table of nonzero 32-bit IDs with insert, lookup, remove, free-ID
// search and clear, one result transaction per input transaction.
// ----------------------------------------------------------------------------
// The IDs live in ascending order in one RAM of TABLE_DEPTH x 32 bits with a
// registered read; a fill count marks the valid prefix, so nothing needs
// clearing after reset and a clear only resets the fill count. Every table
// entry that an operation visits takes a READ step that issues the read and
// an EVAL step that evaluates the returned word and possibly writes one entry
// back. Lookup and the used-ID check stop at the first entry not below the
// ID. Insert walks down from the top of the table, moving each entry not
// below the new ID up by one, and remove walks up to the match and then
// pulls the tail down. Zero IDs for insert, lookup and remove, a full table,
// unknown operations and clear skip the table walk. The block takes one
// transaction at a time; a finished result sits in an output register, so
// the next transaction is accepted while it waits. The range registers are
// written through the APB port at byte addresses 0, 4, 8, 12 (transient min,
// transient max, persistent min, persistent max) and must only be written
// while the block is idle.
// ----------------------------------------------------------------------------
module sorted_id_pool_top #(
  parameter int TABLE_DEPTH = sip_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input transactions
  input  logic                               in_valid,
  output logic                               in_ready,
  input  sip_pkg::sip_in_t                   in_data,
  // result transactions
  output logic                               out_valid,
  input  logic                               out_ready,
  output sip_pkg::sip_out_t                  out_data,
  // configuration (APB)
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sip_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [sip_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [sip_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  import sip_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_DEPTH);

  // ---------------------------------------------------------------- config
  logic [ID_W-1:0] trans_min_r, trans_max_r, pers_min_r, pers_max_r;
  logic            cfg_wr;
  reg_idx_t        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trans_min_r <= ID_W'(1);
      trans_max_r <= ID_MAX;
      pers_min_r  <= ID_W'(1);
      pers_max_r  <= ID_MAX;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TRANS_MIN: trans_min_r <= pwdata;
        REG_TRANS_MAX: trans_max_r <= pwdata;
        REG_PERS_MIN:  pers_min_r  <= pwdata;
        REG_PERS_MAX:  pers_max_r  <= pwdata;
        default:       trans_min_r <= trans_min_r;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_TRANS_MIN: prdata = trans_min_r;
      REG_TRANS_MAX: prdata = trans_max_r;
      REG_PERS_MIN:  prdata = pers_min_r;
      REG_PERS_MAX:  prdata = pers_max_r;
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- table RAM
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr, mem_raddr;
  logic [ID_W-1:0]  mem_wdata, mem_rdata;

  sip_ram #(
    .WIDTH (ID_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------- control
  fsm_t             state_r, state_nxt;
  kind_t            op_r, op_nxt;
  logic             alloc_r, alloc_nxt;     // find_free with item_id zero
  logic             shift_r, shift_nxt;     // remove: pulling the tail down
  logic [ID_W-1:0]  key_r, key_nxt;
  logic [ID_W-1:0]  cand_r, cand_nxt;
  logic [ID_W-1:0]  lim_r, lim_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  status_t          res_st_r, res_st_nxt;
  logic [ID_W-1:0]  res_id_r, res_id_nxt;
  logic             out_valid_r, out_valid_nxt;
  sip_out_t         out_r, out_nxt;
  logic [CNT_W-1:0] ptr_dec, ptr_inc;
  logic [ID_W-1:0]  cand_inc;

  assign ptr_dec  = ptr_r - CNT_ONE;
  assign ptr_inc  = ptr_r + CNT_ONE;
  assign cand_inc = cand_r + ID_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    alloc_r  <= alloc_nxt;
    shift_r  <= shift_nxt;
    key_r    <= key_nxt;
    cand_r   <= cand_nxt;
    lim_r    <= lim_nxt;
    ptr_r    <= ptr_nxt;
    res_st_r <= res_st_nxt;
    res_id_r <= res_id_nxt;
    out_r    <= out_nxt;
  end

  assign in_ready  = (state_r == FSM_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    alloc_nxt     = alloc_r;
    shift_nxt     = shift_r;
    key_nxt       = key_r;
    cand_nxt      = cand_r;
    lim_nxt       = lim_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    res_st_nxt    = res_st_r;
    res_id_nxt    = res_id_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r[IDX_W-1:0];
    mem_wdata     = key_r;
    mem_raddr     = ptr_r[IDX_W-1:0];

    unique case (state_r)
      FSM_IDLE: begin
        if (in_valid) begin
          key_nxt    = in_data.item_id;
          alloc_nxt  = 1'b0;
          shift_nxt  = 1'b0;
          ptr_nxt    = '0;
          res_st_nxt = ST_BAD_PARAM;
          res_id_nxt = '0;
          state_nxt  = FSM_DONE;
          unique case (in_data.kind)
            KIND_INSERT: begin
              op_nxt = KIND_INSERT;
              if (in_data.item_id == '0) begin
                res_st_nxt = ST_BAD_PARAM;
              end else if (cnt_r >= CNT_FULL) begin
                res_st_nxt = ST_FULL;
              end else begin
                ptr_nxt   = cnt_r;      // write target, walks downward
                state_nxt = FSM_READ;
              end
            end
            KIND_LOOKUP, KIND_REMOVE: begin
              op_nxt = kind_t'(in_data.kind);
              if (in_data.item_id != '0) begin
                state_nxt = FSM_READ;
              end
            end
            KIND_FIND_FREE: begin
              op_nxt    = KIND_FIND_FREE;
              alloc_nxt = (in_data.item_id == '0);
              cand_nxt  = in_data.persistent ? pers_min_r : trans_min_r;
              lim_nxt   = in_data.persistent ? pers_max_r : trans_max_r;
              state_nxt = FSM_READ;
            end
            KIND_CLEAR: begin
              op_nxt     = KIND_CLEAR;
              cnt_nxt    = '0;
              res_st_nxt = ST_OK;
            end
            default: begin
              op_nxt     = KIND_CLEAR;
              res_st_nxt = ST_BAD_PARAM;
            end
          endcase
        end
      end

      FSM_READ: begin
        state_nxt = FSM_EVAL;
        if (op_r == KIND_INSERT) begin
          if (ptr_r == '0) begin
            mem_we     = 1'b1;
            cnt_nxt    = cnt_r + CNT_ONE;
            res_st_nxt = ST_OK;
            state_nxt  = FSM_DONE;
          end else begin
            mem_raddr = ptr_dec[IDX_W-1:0];
          end
        end else if (shift_r) begin
          if (ptr_inc >= cnt_r) begin
            cnt_nxt    = cnt_r - CNT_ONE;
            res_st_nxt = ST_OK;
            state_nxt  = FSM_DONE;
          end else begin
            mem_raddr = ptr_inc[IDX_W-1:0];
          end
        end else if (ptr_r >= cnt_r) begin
          // ran off the end of the held entries
          state_nxt = FSM_DONE;
          if (op_r == KIND_FIND_FREE) begin
            res_st_nxt = ST_OK;
            res_id_nxt = alloc_r ? cand_r : key_r;
          end else begin
            res_st_nxt = ST_NOT_FOUND;
          end
        end
      end

      FSM_EVAL: begin
        state_nxt = FSM_READ;
        if (op_r == KIND_INSERT) begin
          mem_we = 1'b1;
          if (mem_rdata >= key_r) begin
            mem_wdata = mem_rdata;
            ptr_nxt   = ptr_dec;
          end else begin
            cnt_nxt    = cnt_r + CNT_ONE;
            res_st_nxt = ST_OK;
            state_nxt  = FSM_DONE;
          end
        end else if (shift_r) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          ptr_nxt   = ptr_inc;
        end else if (op_r == KIND_FIND_FREE && alloc_r) begin
          if (mem_rdata > cand_r) begin
            res_st_nxt = ST_OK;
            res_id_nxt = cand_r;
            state_nxt  = FSM_DONE;
          end else if (cand_r == ID_MAX || cand_inc == lim_r) begin
            res_st_nxt = ST_NO_SPACE;
            state_nxt  = FSM_DONE;
          end else begin
            cand_nxt = cand_inc;
            ptr_nxt  = ptr_inc;
          end
        end else if (mem_rdata < key_r) begin
          ptr_nxt = ptr_inc;
        end else if (mem_rdata == key_r) begin
          state_nxt = FSM_DONE;
          unique case (op_r)
            KIND_LOOKUP:    res_st_nxt = ST_OK;
            KIND_FIND_FREE: res_st_nxt = ST_BAD_PARAM;
            KIND_REMOVE: begin
              shift_nxt = 1'b1;
              state_nxt = FSM_READ;
            end
            default:        res_st_nxt = ST_BAD_PARAM;
          endcase
        end else begin
          state_nxt = FSM_DONE;
          if (op_r == KIND_FIND_FREE) begin
            res_st_nxt = ST_OK;
            res_id_nxt = key_r;
          end else begin
            res_st_nxt = ST_NOT_FOUND;
          end
        end
      end

      FSM_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.status      = res_st_r;
          out_nxt.result_id   = res_id_r;
          out_nxt.entry_count = ENTRY_W'(cnt_r);
          out_valid_nxt       = 1'b1;
          state_nxt           = FSM_IDLE;
        end
      end

      default: state_nxt = FSM_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_FULL)
    else $error("fill count above table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r != FSM_IDLE)
    else $error("accepted transaction did not start");

  a_write_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == FSM_READ || state_r == FSM_EVAL))
    else $error("table write outside of a walk");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == FSM_DONE)
    else $error("result loaded outside of done state");

endmodule
